### src/pasg_pkg.sv
// Package for the phase accumulator sine generator: register map, config types, sine table.
package pasg_pkg;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_PHASE_STEP  = 2'd0,
        REG_AMPLITUDE   = 2'd1,
        REG_START_PHASE = 2'd2,
        REG_RUN_LENGTH  = 2'd3
    } reg_idx_t;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    // Register reset values
    localparam logic [31:0] PHASE_STEP_RST  = 32'd42852281;
    localparam logic [15:0] AMPLITUDE_RST   = 16'd16384;
    localparam logic [31:0] START_PHASE_RST = 32'd0;
    localparam logic [23:0] RUN_LENGTH_RST  = 24'd88200;

    // pi in Q30
    localparam logic [63:0] PI_Q30 = 64'hC90FDAA2;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [31:0] phase_step;
        logic [15:0] amplitude;
        logic [31:0] start_phase;
        logic [23:0] run_length;
    } cfg_t;

    // Side flags carried alongside the table magnitude
    typedef struct packed {
        logic neg;
        logic last;
    } lookup_flags_t;

    // Unsigned 64-bit quotient by restoring long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Quarter-wave table entry, evaluated at elaboration only.
    // Taylor series of sin in Q30 with 64-bit wrapping arithmetic, then rounded to full scale.
    function automatic logic [31:0] rom_value(input int unsigned i,
                                              input int unsigned addr_bits,
                                              input int unsigned sample_bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        div;
        logic [63:0]        ms;
        logic [63:0]        v;
        logic signed [63:0] sum;
        x    = (PI_Q30 * 64'(i)) >> (addr_bits + 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k < 24; k++) begin
            if (term != 64'd0) begin
                div  = 64'(2 * k) * 64'(2 * k + 1);
                term = udiv64((term * x2) >> 30, div);
                if ((k & 1) != 0)
                    sum = sum - signed'(term);
                else
                    sum = sum + signed'(term);
            end
        end
        if (sum < 0)
            sum = '0;
        ms = (64'd1 << (sample_bits - 1)) - 64'd1;
        v  = (64'(sum) * ms + (64'd1 << 29)) >> 30;
        if (v > ms)
            v = ms;
        return v[31:0];
    endfunction

endpackage

### src/pasg_in_if.sv
// Tick channel: one word per requested sample, with a restart flag.
interface pasg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

### src/pasg_out_if.sv
// Sample channel: one signed sample word and an end-of-run flag.
interface pasg_out_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

### src/pasg_regs.sv
// APB register bank holding tuning word, amplitude, start phase and run length.
module pasg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pasg_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [pasg_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [pasg_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    output pasg_pkg::cfg_t                     cfg
);
    import pasg_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t sel_idx;
    logic     wr_en;

    assign sel_idx = reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Register writes, taken in the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step  <= PHASE_STEP_RST;
            cfg_reg.amplitude   <= AMPLITUDE_RST;
            cfg_reg.start_phase <= START_PHASE_RST;
            cfg_reg.run_length  <= RUN_LENGTH_RST;
        end
        else if (wr_en)
        begin
            case (sel_idx)
                REG_PHASE_STEP:  cfg_reg.phase_step  <= pwdata;
                REG_AMPLITUDE:   cfg_reg.amplitude   <= pwdata[15:0];
                REG_START_PHASE: cfg_reg.start_phase <= pwdata;
                REG_RUN_LENGTH:  cfg_reg.run_length  <= pwdata[23:0];
                default:         ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (sel_idx)
            REG_PHASE_STEP:  prdata = cfg_reg.phase_step;
            REG_AMPLITUDE:   prdata = {16'd0, cfg_reg.amplitude};
            REG_START_PHASE: prdata = cfg_reg.start_phase;
            REG_RUN_LENGTH:  prdata = {8'd0, cfg_reg.run_length};
            default:         prdata = '0;
        endcase
    end

endmodule

### src/pasg_phase.sv
// Phase accumulator, run counter and quarter-wave table lookup stage.
module pasg_phase #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16,
    parameter int COUNT_BITS      = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pasg_pkg::cfg_t                cfg,
    input  logic                          accept,
    input  logic                          restart,
    input  logic                          advance,
    output logic                          lk_valid,
    output logic [SAMPLE_BITS-2:0]        lk_mag,
    output pasg_pkg::lookup_flags_t       lk_flags
);
    import pasg_pkg::*;

    localparam int MW    = SAMPLE_BITS - 1;
    localparam int A     = TABLE_ADDR_BITS;
    localparam int DEPTH = 1 << A;
    localparam int CW    = ((COUNT_BITS > 24) ? COUNT_BITS : 24) + 1;
    localparam logic [MW-1:0] MAXS = '1;

    logic [MW-1:0]         rom_tab [DEPTH];
    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [COUNT_BITS-1:0] sample_index_reg;
    logic                  lk_valid_reg;
    logic [MW-1:0]         lk_mag_reg;
    lookup_flags_t         lk_flags_reg;

    logic [PHASE_BITS-1:0] phase_cur;
    logic [PHASE_BITS-1:0] start_ph;
    logic [1:0]            quad;
    logic [A-1:0]          idx;
    logic [A:0]            tab_k;
    logic [MW-1:0]         mag_next;
    logic [COUNT_BITS-1:0] index_cur;
    logic [CW-1:0]         index_inc;
    logic [CW-1:0]         run_len;
    logic                  last_next;

    // Constant quarter-wave table
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_rom
        localparam logic [31:0] ROM_V = rom_value(i, A, SAMPLE_BITS);
        assign rom_tab[i] = ROM_V[MW-1:0];
    end

    // Phase for this tick and mirrored table address
    assign start_ph  = PHASE_BITS'(cfg.start_phase);
    assign phase_cur = restart ? start_ph : phase_acc_reg;
    assign quad      = phase_cur[PHASE_BITS-1 -: 2];
    assign idx       = phase_cur[PHASE_BITS-3 -: A];
    assign tab_k     = quad[0] ? ((A+1)'(DEPTH) - {1'b0, idx}) : {1'b0, idx};
    assign mag_next  = tab_k[A] ? MAXS : rom_tab[tab_k[A-1:0]];

    // End-of-run detection; a zero run length counts as one
    assign index_cur = restart ? '0 : sample_index_reg;
    assign index_inc = CW'(index_cur) + CW'(1);
    assign run_len   = (cfg.run_length == 24'd0) ? CW'(1) : CW'(cfg.run_length);
    assign last_next = (index_inc >= run_len);

    // Accumulator and counter advance, or reload at the end of a run, once per accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg    <= PHASE_BITS'(START_PHASE_RST);
            sample_index_reg <= '0;
        end
        else if (accept)
        begin
            if (last_next)
            begin
                phase_acc_reg    <= start_ph;
                sample_index_reg <= '0;
            end
            else
            begin
                phase_acc_reg    <= phase_cur + PHASE_BITS'(cfg.phase_step);
                sample_index_reg <= index_inc[COUNT_BITS-1:0];
            end
        end
    end

    // Lookup stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lk_valid_reg <= 1'b0;
        else if (advance)
            lk_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lk_mag_reg        <= mag_next;
            lk_flags_reg.neg  <= quad[1];
            lk_flags_reg.last <= last_next;
        end
    end

    assign lk_valid = lk_valid_reg;
    assign lk_mag   = lk_mag_reg;
    assign lk_flags = lk_flags_reg;

endmodule

### src/pasg_scale.sv
// Amplitude scaling, rounding, sign and saturation into the output register.
module pasg_scale #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [15:0]             amplitude,
    input  logic                    lk_valid,
    input  logic [SAMPLE_BITS-2:0]  lk_mag,
    input  pasg_pkg::lookup_flags_t lk_flags,
    output logic                    out_en,
    pasg_out_if.source              wave
);
    import pasg_pkg::*;

    localparam int MW = SAMPLE_BITS - 1;
    localparam int PW = MW + 16 + 1;
    localparam logic [SAMPLE_BITS:0] LIM_NEG = {2'b01, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS:0] LIM_POS = LIM_NEG - 1'b1;

    logic                   valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   last_reg;

    logic [PW-1:0]          prod;
    logic [SAMPLE_BITS:0]   scaled;
    logic [SAMPLE_BITS:0]   clipped;
    logic [SAMPLE_BITS:0]   signed_res;
    logic [SAMPLE_BITS-1:0] sample_next;

    // Magnitude times amplitude, rounded half away from zero
    assign prod   = ({{(PW-MW){1'b0}}, lk_mag} * {{(PW-16){1'b0}}, amplitude})
                    + (PW'(1) << 14);
    assign scaled = prod[PW-1:15];

    // Saturate and apply sign
    always_comb
    begin
        if (lk_flags.neg)
        begin
            clipped    = (scaled > LIM_NEG) ? LIM_NEG : scaled;
            signed_res = '0 - clipped;
        end
        else
        begin
            clipped    = (scaled > LIM_POS) ? LIM_POS : scaled;
            signed_res = clipped;
        end
        sample_next = signed_res[SAMPLE_BITS-1:0];
    end

    // Output register; loads whenever empty or being taken
    assign out_en = !valid_reg || wave.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (out_en)
            valid_reg <= lk_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_en && lk_valid)
        begin
            sample_reg <= sample_next;
            last_reg   <= lk_flags.last;
        end
    end

    assign wave.valid  = valid_reg;
    assign wave.sample = signed'(sample_reg);
    assign wave.last   = last_reg;

endmodule

### src/phase_accumulator_sine_generator.sv
// Top level of the numerically controlled oscillator (phase accumulator sine generator).
//
//   channel  dir  handshake      word
//   tick     in   valid/ready    restart
//   wave     out  valid/ready    sample (signed), last
//   apb      in   psel/penable   phase_step, amplitude, start_phase, run_length
//
// One word is accepted per cycle unless the output stalls, and its sample is registered in
// the lookup register and then the output register, which set the rate and each hold one word.
// Reset clears both stage valids, zeroes the phase and the run counter and loads register defaults.
// A stalled output word holds; tick stays ready while the lookup stage can move forward.
module phase_accumulator_sine_generator #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16,
    parameter int COUNT_BITS      = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pasg_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [pasg_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [pasg_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    pasg_in_if.sink                            tick,
    pasg_out_if.source                         wave
);
    import pasg_pkg::*;

    cfg_t                   cfg;
    logic                   accept;
    logic                   advance;
    logic                   out_en;
    logic                   lk_valid;
    logic [SAMPLE_BITS-2:0] lk_mag;
    lookup_flags_t          lk_flags;

    // Stage hand-off
    assign advance    = !lk_valid || out_en;
    assign tick.ready = advance;
    assign accept     = tick.valid && advance;

    pasg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pasg_phase #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_phase (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .accept   (accept),
        .restart  (tick.restart),
        .advance  (advance),
        .lk_valid (lk_valid),
        .lk_mag   (lk_mag),
        .lk_flags (lk_flags)
    );

    pasg_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .amplitude (cfg.amplitude),
        .lk_valid  (lk_valid),
        .lk_mag    (lk_mag),
        .lk_flags  (lk_flags),
        .out_en    (out_en),
        .wave      (wave)
    );

endmodule

### src/pasg_checker.sv
// Port-level checks for the sine generator, attached to the top level by bind.
module pasg_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] out_sample,
    input logic                   out_last
);

    // An offered word stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word withdrawn before it was taken");

    // A stalled word keeps its contents
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_sample) && $stable(out_last))
        else $error("stalled output word changed");

    // Nothing is offered while reset is held
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // A free or draining output stage never blocks the tick channel
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("tick channel stalled with room in the pipeline");

endmodule

bind phase_accumulator_sine_generator pasg_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_pasg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (tick.ready),
    .out_valid  (wave.valid),
    .out_ready  (wave.ready),
    .out_sample (wave.sample),
    .out_last   (wave.last)
);

### test/phase_accumulator_sine_generator_tb.sv
// Testbench for the phase accumulator sine generator: sample stream checked against a local model.
`timescale 1ns / 1ps

module phase_accumulator_sine_generator_tb;
    import pasg_pkg::*;

    localparam int LIMIT_CYCLES = 100000;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
    } wave_word_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic pready;

    pasg_in_if tick_ch ();
    pasg_out_if #(.SAMPLE_BITS(16)) wave_ch ();

    phase_accumulator_sine_generator uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tick    (tick_ch),
        .wave    (wave_ch)
    );

    // Local copy of the oscillator: settings, phase, run counter, quarter-wave table
    cfg_t        nco_cfg;
    logic [31:0] nco_phase;
    logic [23:0] nco_count;
    logic [15:0] quarter_wave [0:1023];

    logic       pending_ticks [$];
    wave_word_t expected_wave [$];

    int error_count = 0;
    int cycle_count = 0;
    int tick_gap    = 0;
    int wave_stall  = 0;
    bit quiet_tail  = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    // sin(x) in Q30 by the alternating Taylor series, x in Q30 radians
    function automatic logic [63:0] taylor_sin_q30(input logic [63:0] x);
        logic [63:0]        x_sq;
        logic [63:0]        term;
        logic [63:0]        n;
        logic signed [63:0] acc;
        bit                 minus;
        x_sq  = (x * x) >> 30;
        term  = x;
        acc   = signed'(x);
        n     = 64'd1;
        minus = 1'b1;
        while (n < 64'd24 && term != 64'd0)
        begin
            term = ((term * x_sq) >> 30) / ((64'd2 * n) * (64'd2 * n + 64'd1));
            acc  = minus ? acc - signed'(term) : acc + signed'(term);
            minus = !minus;
            n++;
        end
        return (acc < 0) ? 64'd0 : 64'(acc);
    endfunction

    // One tick: sample at the current phase, then advance or reload
    function automatic wave_word_t nco_next_sample(input logic restart);
        wave_word_t  w;
        logic [1:0]  quad;
        logic [9:0]  idx;
        logic [15:0] mag;
        logic [63:0] prod;
        logic [23:0] len;
        if (restart)
        begin
            nco_phase = nco_cfg.start_phase;
            nco_count = '0;
        end
        quad = nco_phase[31:30];
        idx  = nco_phase[29:20];
        if (quad[0])
            mag = (idx == 10'd0) ? 16'd32767 : quarter_wave[11'd1024 - 11'(idx)];
        else
            mag = quarter_wave[idx];
        prod = (64'(mag) * 64'(nco_cfg.amplitude) + 64'd16384) >> 15;
        if (quad[1])
        begin
            if (prod > 64'd32768)
                prod = 64'd32768;
            w.sample = 16'(64'd0 - prod);
        end
        else
        begin
            if (prod > 64'd32767)
                prod = 64'd32767;
            w.sample = prod[15:0];
        end
        len    = (nco_cfg.run_length == '0) ? 24'd1 : nco_cfg.run_length;
        w.last = (25'(nco_count) + 25'd1) >= 25'(len);
        if (w.last)
        begin
            nco_phase = nco_cfg.start_phase;
            nco_count = '0;
        end
        else
        begin
            nco_phase = nco_phase + nco_cfg.phase_step;
            nco_count = nco_count + 24'd1;
        end
        return w;
    endfunction

    // Register write followed by a read back of the masked value
    task automatic cfg_write(input reg_idx_t r, input logic [31:0] data);
        logic [31:0] held;
        case (r)
            REG_PHASE_STEP:  held = data;
            REG_AMPLITUDE:   held = {16'd0, data[15:0]};
            REG_START_PHASE: held = data;
            default:         held = {8'd0, data[23:0]};
        endcase
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (r)
            REG_PHASE_STEP:  nco_cfg.phase_step  = held;
            REG_AMPLITUDE:   nco_cfg.amplitude   = held[15:0];
            REG_START_PHASE: nco_cfg.start_phase = held;
            default:         nco_cfg.run_length  = held[23:0];
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== held)
            report_mismatch($sformatf("register %s reads %h, want %h", r.name(), prdata, held));
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_ticks(input int n, input logic first_restart);
        for (int i = 0; i < n; i++)
            pending_ticks.push_back(i == 0 ? first_restart : 1'b0);
    endtask

    // Wait until every word is sent and every sample has come back
    task automatic drain;
        while (pending_ticks.size() != 0 || tick_ch.valid || expected_wave.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Tick driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tick_ch.valid && tick_ch.ready)
                expected_wave.push_back(nco_next_sample(tick_ch.restart));
            if (!tick_ch.valid || tick_ch.ready)
            begin
                if (tick_gap != 0)
                begin
                    tick_gap--;
                    tick_ch.valid <= 1'b0;
                end
                else if (pending_ticks.size() != 0)
                begin
                    tick_ch.valid   <= 1'b1;
                    tick_ch.restart <= pending_ticks.pop_front();
                    if (!quiet_tail && $urandom_range(3) == 0)
                        tick_gap = $urandom_range(11, 1);
                end
                else
                    tick_ch.valid <= 1'b0;
            end
        end
    end

    // Sample monitor, output stalls and cycle limit
    always @(posedge clk)
    begin
        wave_word_t want;
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
        else if (rst_n)
        begin
            if (wave_ch.valid && wave_ch.ready)
            begin
                if (expected_wave.size() == 0)
                    report_mismatch($sformatf("unexpected word sample %0d", wave_ch.sample));
                else
                begin
                    want = expected_wave.pop_front();
                    if (wave_ch.sample !== want.sample)
                        report_mismatch($sformatf("sample got %0d, want %0d",
                                                  wave_ch.sample, want.sample));
                    if (wave_ch.last !== want.last)
                        report_mismatch($sformatf("last got %b, want %b",
                                                  wave_ch.last, want.last));
                end
            end
            if (wave_stall != 0)
            begin
                wave_stall--;
                wave_ch.ready <= 1'b0;
            end
            else
            begin
                wave_ch.ready <= 1'b1;
                if (!quiet_tail && $urandom_range(5) == 0)
                    wave_stall = $urandom_range(11, 1);
            end
        end
    end

    // Stimulus
    initial
    begin
        int          n_items;
        logic [31:0] upper;
        logic [31:0] step_val;
        logic [31:0] amp_val;
        logic [31:0] len_val;

        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        tick_ch.valid   = 1'b0;
        tick_ch.restart = 1'b0;
        wave_ch.ready   = 1'b0;

        // quarter-wave table, full scale 32767
        for (int i = 0; i < 1024; i++)
        begin
            logic [63:0] v;
            v = (taylor_sin_q30((64'hC90FDAA2 * 64'(i)) >> 11) * 64'd32767 + (64'd1 << 29)) >> 30;
            quarter_wave[i] = (v > 64'd32767) ? 16'd32767 : v[15:0];
        end

        nco_cfg.phase_step  = PHASE_STEP_RST;
        nco_cfg.amplitude   = AMPLITUDE_RST;
        nco_cfg.start_phase = START_PHASE_RST;
        nco_cfg.run_length  = RUN_LENGTH_RST;
        nco_phase           = START_PHASE_RST;
        nco_count           = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings
        pending_ticks.push_back(1'b0);
        pending_ticks.push_back(1'b1);
        pending_ticks.push_back(1'b0);
        drain();

        // quarter-turn steps at full scale: every quadrant edge, wrap into a new run
        cfg_write(REG_PHASE_STEP, 32'h4000_0000);
        cfg_write(REG_AMPLITUDE, 32'd32768);
        cfg_write(REG_START_PHASE, 32'h0000_0000);
        cfg_write(REG_RUN_LENGTH, 32'd5);
        queue_ticks(8, 1'b1);
        drain();

        // amplitude over full scale saturates; zero run length makes every word last
        cfg_write(REG_PHASE_STEP, 32'h2000_0000);
        cfg_write(REG_AMPLITUDE, 32'hA5A5_FFFF);
        cfg_write(REG_START_PHASE, 32'h4000_0000);
        cfg_write(REG_RUN_LENGTH, 32'hFF00_0000);
        queue_ticks(5, 1'b0);
        drain();

        // all-ones phase and step, zero amplitude, longest run
        cfg_write(REG_PHASE_STEP, 32'hFFFF_FFFF);
        cfg_write(REG_AMPLITUDE, 32'hFFFF_0000);
        cfg_write(REG_START_PHASE, 32'hFFFF_FFFF);
        cfg_write(REG_RUN_LENGTH, 32'hFFFF_FFFF);
        queue_ticks(3, 1'b1);
        drain();

        // run shortened part way through, new start phase used at the next reload
        cfg_write(REG_PHASE_STEP, 32'h0100_0000);
        cfg_write(REG_AMPLITUDE, 32'd20000);
        cfg_write(REG_START_PHASE, 32'h1234_5678);
        cfg_write(REG_RUN_LENGTH, 32'd10);
        queue_ticks(6, 1'b1);
        drain();
        cfg_write(REG_RUN_LENGTH, 32'd3);
        cfg_write(REG_START_PHASE, 32'h8000_0000);
        queue_ticks(3, 1'b0);
        drain();

        // random settings, mostly short runs so that run ends come often
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 7)
                quiet_tail = 1'b1;
            upper = ($urandom_range(1) == 0) ? 32'd0 : $urandom;
            case ($urandom_range(5))
                0:       step_val = 32'd0;
                1:       step_val = 32'hFFFF_FFFF;
                2:       step_val = $urandom_range(32'h0010_0000, 1);
                default: step_val = $urandom;
            endcase
            case ($urandom_range(5))
                0:       amp_val = 32'd32768;
                1:       amp_val = {16'd0, 16'($urandom)};
                2:       amp_val = 32'd0;
                default: amp_val = $urandom_range(32768);
            endcase
            case ($urandom_range(9))
                0:       len_val = 32'd0;
                1:       len_val = 32'd1;
                2:       len_val = 32'h00FF_FFFF;
                3:       len_val = {8'd0, 24'($urandom)};
                default: len_val = $urandom_range(40, 2);
            endcase
            cfg_write(REG_PHASE_STEP, step_val);
            cfg_write(REG_AMPLITUDE, amp_val | (upper & 32'hFFFF_0000));
            cfg_write(REG_START_PHASE, $urandom);
            cfg_write(REG_RUN_LENGTH, len_val | (upper & 32'hFF00_0000));
            n_items = $urandom_range(75, 55);
            for (int i = 0; i < n_items; i++)
                pending_ticks.push_back($urandom_range(15) == 0);
            drain();
        end

        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
